FILE: rtl/clrp_pkg.sv
// Shared types and constants for the polyline clearance profiler.
package clrp_pkg;

  // Fixed field widths of the item and result channels.
  localparam int COORD_IN_W = 24;
  localparam int CNT_W      = 24;
  localparam int ACC_W      = 48;
  localparam int LEN_W      = 26;
  localparam int RISE_W     = 25;
  localparam int ELEV_W     = 24;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [ACC_W-1:0] ACC_MAX = '1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SUM,
    ST_ROOT_GO,
    ST_ROOT,
    ST_FINISH
  } st_t;

  // Strobes from the sequencer to the datapath.
  typedef struct packed {
    logic idle;
    logic capture;
    logic sq_x;
    logic sq_y;
    logic sq_z;
    logic sum;
    logic root_start;
    logic finish;
  } ctl_t;

endpackage

FILE: rtl/clrp_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
module clrp_isqrt #(
  parameter int RAD_W = 50
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [RAD_W-1:0]     radicand,
  output logic [RAD_W/2-1:0]   root,
  output logic                 busy,
  output logic                 done
);

  localparam int ROOT_W = RAD_W / 2;
  localparam int CNT_W  = $clog2(ROOT_W);
  localparam int REM_W  = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              fits;

  // One restoring step: bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = (rem_sh >= trial);

  // Iteration control and datapath update.
  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_nxt = {root_r[ROOT_W-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the working registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign root = root_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

FILE: rtl/clrp_ctrl.sv
// Sequencer that steps one item through the shared squarer and the root units.
module clrp_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          first_eff,
  input  logic          root_done,
  input  logic          out_free,
  output clrp_pkg::ctl_t ctl
);

  import clrp_pkg::*;

  st_t state_r, state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = first_eff ? ST_FINISH : ST_SQ_X;
        end
      end
      ST_SQ_X:    state_nxt = ST_SQ_Y;
      ST_SQ_Y:    state_nxt = ST_SQ_Z;
      ST_SQ_Z:    state_nxt = ST_SUM;
      ST_SUM:     state_nxt = ST_ROOT_GO;
      ST_ROOT_GO: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Strobes for the datapath.
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.idle    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_SQ_X:    ctl.sq_x       = 1'b1;
      ST_SQ_Y:    ctl.sq_y       = 1'b1;
      ST_SQ_Z:    ctl.sq_z       = 1'b1;
      ST_SUM:     ctl.sum        = 1'b1;
      ST_ROOT_GO: ctl.root_start = 1'b1;
      ST_ROOT:    ctl            = '0;
      ST_FINISH:  ctl.finish     = out_free;
      default:    ctl            = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/polyline_clearance_profiler_unit.sv
// Top level of the polyline clearance profiler: per-point segment lengths and path statistics.
//
// Usage:
// - Input channel in_*: one path point per item (x, y, z and a first-point flag).
//   An item is taken when in_valid is high and in_stall is low.
// - Result channel out_*: one result item per point, taken when out_valid is high
//   and out_stall is low. The result sits in an output register, so the next
//   point is accepted while a finished result still waits.
// - cfg_wr_en / cfg_wr_data write the clearance threshold; write only while idle.
// Sequence:
// - A first point goes from the idle step straight to the finish step, which
//   writes the result register.
// - Any other point goes through three squarer passes and two sums, then two
//   digit-by-digit roots of COORD_BITS + 1 steps side by side, then the finish step.
// - in_stall stays high while a point is in work.
// Reset (rst_n low, synchronous) empties the block, clears the threshold and
// closes the path, so the next point starts a new path.
// When the receiver stalls, the finished result holds and the sequencer waits
// in its last step until the output register is free.
module polyline_clearance_profiler_unit #(
  parameter int COORD_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Configuration
  input  logic                                   cfg_wr_en,
  input  logic [clrp_pkg::LEN_W-1:0]             cfg_wr_data,
  // Input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_first_point,
  input  logic signed [clrp_pkg::COORD_IN_W-1:0] in_coord_x,
  input  logic signed [clrp_pkg::COORD_IN_W-1:0] in_coord_y,
  input  logic signed [clrp_pkg::COORD_IN_W-1:0] in_coord_z,
  // Result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [clrp_pkg::CNT_W-1:0]             out_point_number,
  output logic [clrp_pkg::ACC_W-1:0]             out_chainage,
  output logic [clrp_pkg::LEN_W-1:0]             out_horizontal_length,
  output logic [clrp_pkg::LEN_W-1:0]             out_spatial_length,
  output logic signed [clrp_pkg::RISE_W-1:0]     out_rise,
  output logic                                   out_below_threshold,
  output logic [clrp_pkg::CNT_W-1:0]             out_warning_total,
  output logic signed [clrp_pkg::ELEV_W-1:0]     out_lowest_elevation,
  output logic signed [clrp_pkg::ELEV_W-1:0]     out_highest_elevation,
  output logic [clrp_pkg::LEN_W-1:0]             out_shortest_segment,
  output logic [clrp_pkg::LEN_W-1:0]             out_longest_segment,
  output logic [clrp_pkg::ACC_W-1:0]             out_path_length
);

  import clrp_pkg::*;

  localparam int CW     = COORD_BITS;
  localparam int DW     = COORD_BITS + 1;
  localparam int RAD_W  = 2 * DW;
  localparam int ROOT_W = DW;
  localparam int LW     = (ROOT_W > LEN_W) ? ROOT_W : LEN_W;
  localparam int RW     = (DW > RISE_W) ? DW : RISE_W;
  localparam int EW     = (CW > ELEV_W) ? CW : ELEV_W;

  localparam logic signed [RW-1:0] RISE_HI = RW'((2 ** (RISE_W - 1)) - 1);
  localparam logic signed [RW-1:0] RISE_LO = -RISE_HI - RW'(1);
  localparam logic signed [EW-1:0] ELEV_HI = EW'((2 ** (ELEV_W - 1)) - 1);
  localparam logic signed [EW-1:0] ELEV_LO = -ELEV_HI - EW'(1);

  ctl_t ctl;

  // Configuration and path status.
  logic [LEN_W-1:0] thr_r;
  logic             open_r;
  logic             first_eff;

  // Captured point and deltas.
  logic signed [CW-1:0] x_c, y_c, z_c;
  logic signed [CW-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic signed [CW-1:0] z_r;
  logic                 first_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;

  // Shared squarer and sums.
  logic signed [DW-1:0] mul_d;
  logic [DW-1:0]        mag;
  logic [RAD_W-1:0]     prod_c;
  logic [RAD_W-1:0]     prod_r;
  logic [RAD_W-1:0]     h2_r;
  logic [RAD_W-1:0]     s2_r;

  // Root units.
  logic [ROOT_W-1:0] h_root, s_root;
  logic              h_busy, s_busy, h_done, s_done;

  // Running path state.
  logic [CNT_W-1:0]     cnt_r,   cnt_nxt;
  logic [ACC_W-1:0]     chain_r, chain_nxt;
  logic [ACC_W-1:0]     plen_r,  plen_nxt;
  logic [CNT_W-1:0]     warn_r,  warn_nxt;
  logic signed [CW-1:0] elo_r,   elo_nxt;
  logic signed [CW-1:0] ehi_r,   ehi_nxt;
  logic [LEN_W-1:0]     seglo_r, seglo_nxt;
  logic [LEN_W-1:0]     seghi_r, seghi_nxt;

  // Finish-step helpers.
  logic [CNT_W-1:0]     index;
  logic [ACC_W-1:0]     chain_b, plen_b;
  logic [CNT_W-1:0]     warn_b;
  logic signed [CW-1:0] elo_b, ehi_b;
  logic [LW-1:0]        h_root_w, s_root_w;
  logic [LEN_W-1:0]     hlen, slen;
  logic                 below;
  logic [ACC_W:0]       chain_sum, plen_sum;
  logic signed [RW-1:0] dz_w;
  logic signed [RISE_W-1:0] rise_c;
  logic signed [EW-1:0] elo_w, ehi_w;
  logic signed [ELEV_W-1:0] elo_c, ehi_c;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_free;
  logic [CNT_W-1:0]         o_num_r;
  logic [ACC_W-1:0]         o_chain_r;
  logic [LEN_W-1:0]         o_hlen_r, o_slen_r;
  logic signed [RISE_W-1:0] o_rise_r;
  logic                     o_below_r;
  logic [CNT_W-1:0]         o_warn_r;
  logic signed [ELEV_W-1:0] o_elo_r, o_ehi_r;
  logic [LEN_W-1:0]         o_seglo_r, o_seghi_r;
  logic [ACC_W-1:0]         o_plen_r;

  // Coordinates: the low COORD_BITS bits, taken as a signed value; wider settings see the
  // 24-bit field as a non-negative value.
  generate
    if (CW <= COORD_IN_W) begin : g_narrow
      assign x_c = in_coord_x[CW-1:0];
      assign y_c = in_coord_y[CW-1:0];
      assign z_c = in_coord_z[CW-1:0];
    end else begin : g_wide
      assign x_c = {{(CW - COORD_IN_W){1'b0}}, in_coord_x};
      assign y_c = {{(CW - COORD_IN_W){1'b0}}, in_coord_y};
      assign z_c = {{(CW - COORD_IN_W){1'b0}}, in_coord_z};
    end
  endgenerate

  assign first_eff = in_first_point | ~open_r;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign in_stall  = ~ctl.idle;

  clrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .first_eff (first_eff),
    .root_done (s_done),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  // Configuration register and path-open flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= '0;
      open_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (ctl.capture) begin
        open_r <= 1'b1;
      end
    end
  end

  // Capture the point, form the deltas and move the previous point along.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      first_r  <= first_eff;
      z_r      <= z_c;
      dx_r     <= DW'(x_c) - DW'(prev_x_r);
      dy_r     <= DW'(y_c) - DW'(prev_y_r);
      dz_r     <= DW'(z_c) - DW'(prev_z_r);
      prev_x_r <= x_c;
      prev_y_r <= y_c;
      prev_z_r <= z_c;
    end
  end

  // Shared squarer: one delta per cycle, product registered before any sum.
  always_comb begin
    if (ctl.sq_x) begin
      mul_d = dx_r;
    end else if (ctl.sq_y) begin
      mul_d = dy_r;
    end else begin
      mul_d = dz_r;
    end
  end

  assign mag    = mul_d[DW-1] ? DW'(-mul_d) : DW'(mul_d);
  assign prod_c = mag * mag;

  always_ff @(posedge clk) begin
    if (ctl.sq_x || ctl.sq_y || ctl.sq_z) begin
      prod_r <= prod_c;
    end
    if (ctl.sq_y) begin
      h2_r <= prod_r;
    end else if (ctl.sq_z) begin
      h2_r <= h2_r + prod_r;
    end
    if (ctl.sum) begin
      s2_r <= h2_r + prod_r;
    end
  end

  // Horizontal and spatial roots run side by side.
  clrp_isqrt #(.RAD_W(RAD_W)) u_root_h (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.root_start),
    .radicand (h2_r),
    .root     (h_root),
    .busy     (h_busy),
    .done     (h_done)
  );

  clrp_isqrt #(.RAD_W(RAD_W)) u_root_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.root_start),
    .radicand (s2_r),
    .root     (s_root),
    .busy     (s_busy),
    .done     (s_done)
  );

  // Lengths clamp to the result width.
  assign h_root_w = LW'(h_root);
  assign s_root_w = LW'(s_root);

  // Finish step: fold the segment into the running path values.
  always_comb begin
    index   = first_r ? '0 : cnt_r;
    chain_b = first_r ? '0 : chain_r;
    plen_b  = first_r ? '0 : plen_r;
    warn_b  = first_r ? '0 : warn_r;
    elo_b   = first_r ? z_r : elo_r;
    ehi_b   = first_r ? z_r : ehi_r;

    cnt_nxt = (index != CNT_MAX) ? index + 1'b1 : index;
    elo_nxt = (z_r < elo_b) ? z_r : elo_b;
    ehi_nxt = (z_r > ehi_b) ? z_r : ehi_b;

    hlen = '0;
    slen = '0;
    dz_w = '0;
    if (!first_r) begin
      hlen = (h_root_w > LW'(LEN_MAX)) ? LEN_MAX : h_root_w[LEN_W-1:0];
      slen = (s_root_w > LW'(LEN_MAX)) ? LEN_MAX : s_root_w[LEN_W-1:0];
      dz_w = RW'(dz_r);
    end
    below = ~first_r && (thr_r != '0) && (slen < thr_r);

    chain_sum = {1'b0, chain_b} + (ACC_W + 1)'(hlen);
    plen_sum  = {1'b0, plen_b} + (ACC_W + 1)'(slen);
    chain_nxt = chain_sum[ACC_W] ? ACC_MAX : chain_sum[ACC_W-1:0];
    plen_nxt  = plen_sum[ACC_W] ? ACC_MAX : plen_sum[ACC_W-1:0];
    warn_nxt  = (below && warn_b != CNT_MAX) ? warn_b + 1'b1 : warn_b;

    if (first_r) begin
      seglo_nxt = '0;
      seghi_nxt = '0;
    end else if (index == CNT_W'(1)) begin
      seglo_nxt = slen;
      seghi_nxt = slen;
    end else begin
      seglo_nxt = (slen < seglo_r) ? slen : seglo_r;
      seghi_nxt = (slen > seghi_r) ? slen : seghi_r;
    end

    // Signed outputs clamp to their ranges.
    if (dz_w > RISE_HI) begin
      rise_c = RISE_HI[RISE_W-1:0];
    end else if (dz_w < RISE_LO) begin
      rise_c = RISE_LO[RISE_W-1:0];
    end else begin
      rise_c = dz_w[RISE_W-1:0];
    end
    elo_w = EW'(elo_nxt);
    ehi_w = EW'(ehi_nxt);
    if (elo_w > ELEV_HI) begin
      elo_c = ELEV_HI[ELEV_W-1:0];
    end else if (elo_w < ELEV_LO) begin
      elo_c = ELEV_LO[ELEV_W-1:0];
    end else begin
      elo_c = elo_w[ELEV_W-1:0];
    end
    if (ehi_w > ELEV_HI) begin
      ehi_c = ELEV_HI[ELEV_W-1:0];
    end else if (ehi_w < ELEV_LO) begin
      ehi_c = ELEV_LO[ELEV_W-1:0];
    end else begin
      ehi_c = ehi_w[ELEV_W-1:0];
    end
  end

  // Running path state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      chain_r <= '0;
      plen_r  <= '0;
      warn_r  <= '0;
      elo_r   <= '0;
      ehi_r   <= '0;
      seglo_r <= '0;
      seghi_r <= '0;
    end else if (ctl.finish) begin
      cnt_r   <= cnt_nxt;
      chain_r <= chain_nxt;
      plen_r  <= plen_nxt;
      warn_r  <= warn_nxt;
      elo_r   <= elo_nxt;
      ehi_r   <= ehi_nxt;
      seglo_r <= seglo_nxt;
      seghi_r <= seghi_nxt;
    end
  end

  // Output register and its valid flag.
  assign out_valid_nxt = ctl.finish | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      o_num_r   <= index;
      o_chain_r <= chain_nxt;
      o_hlen_r  <= hlen;
      o_slen_r  <= slen;
      o_rise_r  <= rise_c;
      o_below_r <= below;
      o_warn_r  <= warn_nxt;
      o_elo_r   <= elo_c;
      o_ehi_r   <= ehi_c;
      o_seglo_r <= seglo_nxt;
      o_seghi_r <= seghi_nxt;
      o_plen_r  <= plen_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_point_number      = o_num_r;
  assign out_chainage          = o_chain_r;
  assign out_horizontal_length = o_hlen_r;
  assign out_spatial_length    = o_slen_r;
  assign out_rise              = o_rise_r;
  assign out_below_threshold   = o_below_r;
  assign out_warning_total     = o_warn_r;
  assign out_lowest_elevation  = o_elo_r;
  assign out_highest_elevation = o_ehi_r;
  assign out_shortest_segment  = o_seglo_r;
  assign out_longest_segment   = o_seghi_r;
  assign out_path_length       = o_plen_r;

`ifndef ASSERT_OFF
  // No new item is taken while the roots are still iterating.
  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (h_busy || s_busy) |-> in_stall)
    else $error("item accepted while root units busy");

  // Both root units start together and must finish together.
  a_roots_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    h_done == s_done)
    else $error("root units out of step");

  // A flagged segment is really shorter than the threshold.
  a_below_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_below_threshold) |->
      (out_spatial_length < thr_r && thr_r != '0))
    else $error("below flag disagrees with threshold");

  // The first point of a path carries no segment.
  a_first_no_segment: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_point_number == '0) |->
      (out_spatial_length == '0 && out_horizontal_length == '0 && out_rise == '0))
    else $error("first point reports a segment");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the polyline clearance profiler: predicted results vs. RTL.
`timescale 1ns / 1ps

module tb_top;
  import clrp_pkg::*;

  localparam logic signed [COORD_IN_W-1:0] COORD_MIN = 24'sh800000;
  localparam logic signed [COORD_IN_W-1:0] COORD_MAX = 24'sh7FFFFF;

  // Expected contents of one result item.
  typedef struct {
    logic [CNT_W-1:0]         point_number;
    logic [ACC_W-1:0]         chainage;
    logic [LEN_W-1:0]         horizontal_length;
    logic [LEN_W-1:0]         spatial_length;
    logic signed [RISE_W-1:0] rise;
    logic                     below_threshold;
    logic [CNT_W-1:0]         warning_total;
    logic signed [ELEV_W-1:0] lowest_elevation;
    logic signed [ELEV_W-1:0] highest_elevation;
    logic [LEN_W-1:0]         shortest_segment;
    logic [LEN_W-1:0]         longest_segment;
    logic [ACC_W-1:0]         path_length;
  } profile_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_wr_en = 1'b0;
  logic [LEN_W-1:0]                cfg_wr_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            in_first_point = 1'b0;
  logic signed [COORD_IN_W-1:0]    in_coord_x = '0;
  logic signed [COORD_IN_W-1:0]    in_coord_y = '0;
  logic signed [COORD_IN_W-1:0]    in_coord_z = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [CNT_W-1:0]                out_point_number;
  logic [ACC_W-1:0]                out_chainage;
  logic [LEN_W-1:0]                out_horizontal_length;
  logic [LEN_W-1:0]                out_spatial_length;
  logic signed [RISE_W-1:0]        out_rise;
  logic                            out_below_threshold;
  logic [CNT_W-1:0]                out_warning_total;
  logic signed [ELEV_W-1:0]        out_lowest_elevation;
  logic signed [ELEV_W-1:0]        out_highest_elevation;
  logic [LEN_W-1:0]                out_shortest_segment;
  logic [LEN_W-1:0]                out_longest_segment;
  logic [ACC_W-1:0]                out_path_length;

  // Tracked path state and threshold, mirrored from the block's behavior.
  longint                   prev_x, prev_y, prev_z;
  logic [CNT_W-1:0]         points_seen;
  logic [ACC_W-1:0]         chainage_sum;
  logic [ACC_W-1:0]         length_sum;
  logic [CNT_W-1:0]         warning_count;
  logic signed [ELEV_W-1:0] elev_low, elev_high;
  logic [LEN_W-1:0]         seg_low, seg_high;
  bit                       path_open;
  logic [LEN_W-1:0]         threshold;

  profile_t pending_profiles[$];
  int       mismatch_count = 0;

  // Stimulus-side bookkeeping.
  logic signed [COORD_IN_W-1:0] walk_x = '0, walk_y = '0, walk_z = '0;
  bit tx_gaps_on   = 1'b1;
  bit rx_stalls_on = 1'b1;
  int hold_request = 0;
  int hold_left    = 0;
  int stall_left   = 0;

  polyline_clearance_profiler_unit u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_first_point        (in_first_point),
    .in_coord_x            (in_coord_x),
    .in_coord_y            (in_coord_y),
    .in_coord_z            (in_coord_z),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_point_number      (out_point_number),
    .out_chainage          (out_chainage),
    .out_horizontal_length (out_horizontal_length),
    .out_spatial_length    (out_spatial_length),
    .out_rise              (out_rise),
    .out_below_threshold   (out_below_threshold),
    .out_warning_total     (out_warning_total),
    .out_lowest_elevation  (out_lowest_elevation),
    .out_highest_elevation (out_highest_elevation),
    .out_shortest_segment  (out_shortest_segment),
    .out_longest_segment   (out_longest_segment),
    .out_path_length       (out_path_length)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor square root, found one result bit at a time from the top.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void clear_profile();
    prev_x = 0;
    prev_y = 0;
    prev_z = 0;
    points_seen = '0;
    chainage_sum = '0;
    length_sum = '0;
    warning_count = '0;
    elev_low = '0;
    elev_high = '0;
    seg_low = '0;
    seg_high = '0;
    path_open = 1'b0;
    threshold = '0;
  endfunction

  // Advances the tracked path by one point and returns the result it must produce.
  function automatic profile_t profile_point(bit first_flag, logic signed [COORD_IN_W-1:0] x,
                                             logic signed [COORD_IN_W-1:0] y,
                                             logic signed [COORD_IN_W-1:0] z);
    profile_t        r;
    bit              starts;
    longint          dx, dy, dz;
    longint unsigned h2, hl, sl;
    logic [CNT_W-1:0] idx;
    starts = first_flag || !path_open;
    if (starts) begin
      points_seen = '0;
      chainage_sum = '0;
      length_sum = '0;
      warning_count = '0;
      elev_low = z;
      elev_high = z;
      seg_low = '0;
      seg_high = '0;
      path_open = 1'b1;
    end
    idx = points_seen;
    if (points_seen < CNT_MAX) points_seen++;
    if (z < elev_low) elev_low = z;
    if (z > elev_high) elev_high = z;

    r.horizontal_length = '0;
    r.spatial_length = '0;
    r.rise = '0;
    r.below_threshold = 1'b0;
    if (!starts) begin
      dx = longint'(x) - prev_x;
      dy = longint'(y) - prev_y;
      dz = longint'(z) - prev_z;
      h2 = dx * dx + dy * dy;
      hl = floor_sqrt(h2);
      sl = floor_sqrt(h2 + dz * dz);
      if (hl > LEN_MAX) hl = LEN_MAX;
      if (sl > LEN_MAX) sl = LEN_MAX;
      r.horizontal_length = hl[LEN_W-1:0];
      r.spatial_length = sl[LEN_W-1:0];
      r.rise = dz[RISE_W-1:0];
      r.below_threshold = (threshold != 0) && (sl < threshold);
      chainage_sum = (chainage_sum + hl > ACC_MAX) ? ACC_MAX : chainage_sum + hl;
      length_sum = (length_sum + sl > ACC_MAX) ? ACC_MAX : length_sum + sl;
      if (r.below_threshold && warning_count < CNT_MAX) warning_count++;
      // The first segment of a path seeds both extremes.
      if (idx == 1) begin
        seg_low = sl[LEN_W-1:0];
        seg_high = sl[LEN_W-1:0];
      end else begin
        if (sl < seg_low) seg_low = sl[LEN_W-1:0];
        if (sl > seg_high) seg_high = sl[LEN_W-1:0];
      end
    end
    prev_x = x;
    prev_y = y;
    prev_z = z;

    r.point_number = idx;
    r.chainage = chainage_sum;
    r.warning_total = warning_count;
    r.lowest_elevation = elev_low;
    r.highest_elevation = elev_high;
    r.shortest_segment = seg_low;
    r.longest_segment = seg_high;
    r.path_length = length_sum;
    return r;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compares one accepted result item against the oldest prediction.
  function automatic void check_result();
    profile_t want;
    if (pending_profiles.size() == 0) begin
      $error("unexpected result item, point_number %0d", out_point_number);
      mismatch_count++;
      return;
    end
    want = pending_profiles.pop_front();
    check_field("point_number", want.point_number, out_point_number);
    check_field("chainage", want.chainage, out_chainage);
    check_field("horizontal_length", want.horizontal_length, out_horizontal_length);
    check_field("spatial_length", want.spatial_length, out_spatial_length);
    check_field("rise", want.rise, out_rise);
    check_field("below_threshold", want.below_threshold, out_below_threshold);
    check_field("warning_total", want.warning_total, out_warning_total);
    check_field("lowest_elevation", want.lowest_elevation, out_lowest_elevation);
    check_field("highest_elevation", want.highest_elevation, out_highest_elevation);
    check_field("shortest_segment", want.shortest_segment, out_shortest_segment);
    check_field("longest_segment", want.longest_segment, out_longest_segment);
    check_field("path_length", want.path_length, out_path_length);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_result();
  end

  // Result-side stall: a requested hold-off, random bursts, or always ready.
  always @(posedge clk) begin
    int unsigned pick;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!rx_stalls_on) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = (pick < 96) ? $urandom_range(0, 3) : $urandom_range(10, 60);
        out_stall <= 1'b1;
      end
    end
  end

  // Idle cycles after an item: mostly none or short, now and then long.
  function automatic int unsigned idle_gap();
    int unsigned pick;
    if (!tx_gaps_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  // Next coordinate of a random walk: same spot, small or medium step, or anywhere.
  function automatic logic signed [COORD_IN_W-1:0] step_coord(
      logic signed [COORD_IN_W-1:0] base);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return base;
    if (pick < 55) return base + COORD_IN_W'($urandom_range(0, 30) - 15);
    if (pick < 85) return base + COORD_IN_W'($urandom_range(0, 20000) - 10000);
    return COORD_IN_W'($urandom);
  endfunction

  // Offers one point, waits until it is taken and records its expected result.
  task automatic send_point(bit first_flag, logic signed [COORD_IN_W-1:0] x,
                            logic signed [COORD_IN_W-1:0] y,
                            logic signed [COORD_IN_W-1:0] z);
    int unsigned gap;
    in_first_point <= first_flag;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_profiles.push_back(profile_point(first_flag, x, y, z));
    walk_x = x;
    walk_y = y;
    walk_z = z;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering items until every expected result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_profiles.size() != 0);
  endtask

  // Threshold write; only called while the block is idle.
  task automatic write_threshold(logic [LEN_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold = value;
    @(posedge clk);
  endtask

  // Points without a first-point flag right after reset start a path anyway.
  task automatic test_open_without_first();
    send_point(1'b0, 24'sd100, -24'sd200, 24'sd300);
    send_point(1'b0, 24'sd103, -24'sd196, 24'sd300);
    send_point(1'b0, 24'sd103, -24'sd196, -24'sd300);
    wait_for_results();
  endtask

  // Full-scale coordinates and the longest possible segments, plus a zero-length one.
  task automatic test_coordinate_extremes();
    send_point(1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
    send_point(1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
    send_point(1'b0, COORD_MIN, COORD_MAX, COORD_MIN);
    send_point(1'b0, COORD_MAX, COORD_MIN, 24'sd0);
    send_point(1'b0, 24'sd0, 24'sd0, 24'sd0);
    send_point(1'b0, 24'sd0, 24'sd0, 24'sd0);
    wait_for_results();
  endtask

  // Segments just under, equal to and over the threshold, then the extreme settings.
  task automatic test_threshold_edges();
    write_threshold(LEN_W'(5));
    send_point(1'b1, 24'sd0, 24'sd0, 24'sd0);
    send_point(1'b0, 24'sd3, 24'sd4, 24'sd0);
    send_point(1'b0, 24'sd3, 24'sd4, 24'sd4);
    send_point(1'b0, 24'sd0, 24'sd0, 24'sd0);
    send_point(1'b0, 24'sd0, 24'sd0, 24'sd1);
    wait_for_results();
    write_threshold(LEN_MAX);
    send_point(1'b1, 24'sd10, 24'sd10, 24'sd10);
    send_point(1'b0, 24'sd11, 24'sd10, 24'sd10);
    send_point(1'b0, COORD_MIN, COORD_MAX, COORD_MIN);
    wait_for_results();
    write_threshold('0);
    send_point(1'b1, 24'sd7, 24'sd7, 24'sd7);
    send_point(1'b0, 24'sd7, 24'sd7, 24'sd7);
    wait_for_results();
  endtask

  // A first-point flag in the middle of a path clears all running values.
  task automatic test_path_restart();
    write_threshold(LEN_W'(1000));
    send_point(1'b1, 24'sd0, 24'sd0, 24'sd50);
    send_point(1'b0, 24'sd600, 24'sd800, -24'sd50);
    send_point(1'b1, -24'sd5, 24'sd5, 24'sd9);
    send_point(1'b0, -24'sd5, 24'sd6, 24'sd9);
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while points keep coming.
  task automatic test_output_hold();
    tx_gaps_on = 1'b0;
    hold_request = 300;
    send_point(1'b1, step_coord(walk_x), step_coord(walk_y), step_coord(walk_z));
    repeat (7) send_point(1'b0, step_coord(walk_x), step_coord(walk_y), step_coord(walk_z));
    tx_gaps_on = 1'b1;
    wait_for_results();
  endtask

  // Random paths: mostly well-formed walks, now and then an early restart.
  task automatic test_random_paths(int unsigned n_items);
    int unsigned left;
    left = 0;
    repeat (n_items) begin
      if (left == 0 || $urandom_range(0, 99) < 3) begin
        left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
        send_point(1'b1, step_coord(walk_x), step_coord(walk_y), step_coord(walk_z));
      end else begin
        send_point(1'b0, step_coord(walk_x), step_coord(walk_y), step_coord(walk_z));
      end
      left--;
    end
    wait_for_results();
  endtask

  // The sender pauses in the middle of a path until the block is empty.
  task automatic test_sender_pause();
    send_point(1'b1, step_coord(walk_x), step_coord(walk_y), step_coord(walk_z));
    repeat (4) send_point(1'b0, step_coord(walk_x), step_coord(walk_y), step_coord(walk_z));
    wait_for_results();
    repeat (5) send_point(1'b0, step_coord(walk_x), step_coord(walk_y), step_coord(walk_z));
    wait_for_results();
  endtask

  task automatic finish_run();
    wait_for_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  endtask

  initial begin
    clear_profile();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_open_without_first();
    test_coordinate_extremes();
    test_threshold_edges();
    test_path_restart();

    write_threshold(LEN_W'($urandom_range(10, 3000)));
    test_random_paths(150);

    // A stretch with no idling on either side.
    write_threshold('0);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    test_random_paths(100);
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;

    write_threshold(LEN_W'(1));
    test_random_paths(100);
    test_output_hold();
    write_threshold(LEN_MAX);
    test_random_paths(50);
    test_sender_pause();
    write_threshold(LEN_W'($urandom));
    test_random_paths(100);

    finish_run();
  end

  // Guard against a hung handshake.
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
